// ===== sv/umpf_pkg.sv =====
// Shared types, codes and constant tables for the MIDI port framer.
package umpf_pkg;

   localparam logic [15:0] BASE_PORT_RESET = 16'h0330;

   localparam logic [7:0] CMD_UART_MODE  = 8'h3f;
   localparam logic [7:0] CMD_RESET      = 8'hff;
   localparam logic [7:0] DATA_READ_BYTE = 8'hfe;
   localparam logic [7:0] STATUS_NODATA  = 8'h80;
   localparam logic [7:0] STATUS_CLEAR   = 8'h00;
   localparam logic [7:0] MIDI_SYSEX     = 8'hf0;
   localparam logic [7:0] MIDI_EOX       = 8'hf7;
   localparam logic [7:0] MIDI_RESET     = 8'hff;

   localparam logic [3:0] SX_POS_MAX    = 4'd15;
   localparam logic [3:0] SX_GM_VOL_POS = 4'd6;
   localparam logic [3:0] SX_GS_VOL_POS = 4'd8;
   localparam logic [3:0] SX_GS_RST_END = 4'd10;
   localparam logic [3:0] SX_GM_RST_END = 4'd5;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef enum logic [1:0] {
      ACC_DATA_READ,
      ACC_STATUS_READ,
      ACC_COMMAND,
      ACC_DATA_WRITE
   } access_kind_type;

   typedef enum logic [2:0] {
      EV_NONE,
      EV_CHANNEL,
      EV_SYS_RESET,
      EV_SYSEX_RESET,
      EV_VOLUME
   } event_kind_type;

   typedef struct packed {
      access_kind_type kind;
      logic [7:0]      data;
   } cmd_type;

   typedef struct packed {
      logic [6:0]     master_volume;
      logic [1:0]     msg_length;
      logic [7:0]     msg_data_two;
      logic [7:0]     msg_data_one;
      logic [7:0]     msg_status;
      event_kind_type event_kind;
      logic [7:0]     read_data;
   } rsp_type;

   // message length by status high nibble, decoded from bits 6:4
   function automatic logic [1:0] frame_len(input logic [2:0] hi);
      case (hi)
         3'd4, 3'd5: frame_len = 2'd2;
         3'd7:       frame_len = 2'd1;
         default:    frame_len = 2'd3;
      endcase
   endfunction

   function automatic logic [7:0] gs_reset_body(input logic [3:0] p);
      case (p)
         4'd1:    gs_reset_body = 8'h41;
         4'd2:    gs_reset_body = 8'h10;
         4'd3:    gs_reset_body = 8'h42;
         4'd4:    gs_reset_body = 8'h12;
         4'd5:    gs_reset_body = 8'h40;
         4'd6:    gs_reset_body = 8'h00;
         4'd7:    gs_reset_body = 8'h7f;
         4'd8:    gs_reset_body = 8'h00;
         4'd9:    gs_reset_body = 8'h41;
         default: gs_reset_body = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] gm_reset_body(input logic [3:0] p);
      case (p)
         4'd1:    gm_reset_body = 8'h7e;
         4'd2:    gm_reset_body = 8'h7f;
         4'd3:    gm_reset_body = 8'h09;
         4'd4:    gm_reset_body = 8'h01;
         default: gm_reset_body = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] gs_vol_body(input logic [3:0] p);
      case (p)
         4'd1:    gs_vol_body = 8'h41;
         4'd3:    gs_vol_body = 8'h42;
         4'd4:    gs_vol_body = 8'h12;
         4'd5:    gs_vol_body = 8'h40;
         4'd6:    gs_vol_body = 8'h00;
         4'd7:    gs_vol_body = 8'h04;
         default: gs_vol_body = 8'h00;
      endcase
   endfunction

   function automatic logic [7:0] gm_vol_body(input logic [3:0] p);
      case (p)
         4'd1:    gm_vol_body = 8'h7f;
         4'd2:    gm_vol_body = 8'h7f;
         4'd3:    gm_vol_body = 8'h04;
         4'd4:    gm_vol_body = 8'h01;
         default: gm_vol_body = 8'h00;
      endcase
   endfunction

   function automatic logic [6:0] clamp7(input logic [7:0] v);
      clamp7 = v[7] ? 7'h7f : v[6:0];
   endfunction

endpackage

// ===== sv/umpf_front.sv =====
// Front end: base port register, address decode and access classification.
module umpf_front (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_valid,
   output logic             csr_ready,
   input  logic [15:0]      csr_data,
   input  logic             req_tvalid,
   output logic             req_tready,
   input  logic [23:0]      req_tdata,
   input  logic             req_tuser,
   output logic             push_valid,
   output umpf_pkg::cmd_type push_cmd,
   input  logic             queue_full
);
   import umpf_pkg::*;

   logic [15:0] base_port_ff;
   logic [15:0] base_port_in;
   logic [15:0] cmd_port;
   logic [15:0] addr;

   assign csr_ready    = 1'b1;
   assign base_port_in = (csr_valid && csr_ready) ? csr_data : base_port_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         base_port_ff <= BASE_PORT_RESET;
      end else begin
         base_port_ff <= base_port_in;
      end
   end

   assign addr       = req_tdata[15:0];
   assign cmd_port   = base_port_ff + 16'd1;
   assign req_tready = !queue_full;
   assign push_valid = req_tvalid && !queue_full;

   always_comb begin
      push_cmd.data = req_tdata[23:16];
      if (!req_tuser) begin
         push_cmd.kind = (addr == base_port_ff) ? ACC_DATA_READ : ACC_STATUS_READ;
      end else begin
         push_cmd.kind = (addr == cmd_port) ? ACC_COMMAND : ACC_DATA_WRITE;
      end
   end

endmodule

// ===== sv/umpf_queue.sv =====
// Two-entry queue of classified accesses between front and back end.
module umpf_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   input  umpf_pkg::cmd_type push_cmd,
   output logic              full,
   output logic              pop_valid,
   output umpf_pkg::cmd_type pop_cmd,
   input  logic              pop
);
   import umpf_pkg::*;

   cmd_type             entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff;
   logic [QPTR_W-1:0]   wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff;
   logic [QPTR_W-1:0]   rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff;
   logic [QCNT_W-1:0]   count_in;
   logic                do_pop;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_cmd   = entry_ff[rd_ptr_ff];
   assign do_pop    = pop && pop_valid;

   always_comb begin
      wr_ptr_in = push_valid ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push_valid && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (!push_valid && do_pop) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_valid) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue count out of range");

   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push_valid && !do_pop) |=> (count_ff == $past(count_ff) + QCNT_W'(1)))
      else $error("queue count missed a push");

endmodule

// ===== sv/umpf_back.sv =====
// Back end: port state, MIDI framing, sysex matching and result register.
module umpf_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              cmd_valid,
   input  umpf_pkg::cmd_type cmd,
   output logic              cmd_pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output umpf_pkg::rsp_type rsp
);
   import umpf_pkg::*;

   logic       no_data_ff,      no_data_in;
   logic       reset_pend_ff,   reset_pend_in;
   logic       in_sysex_ff,     in_sysex_in;
   logic [7:0] part_status_ff,  part_status_in;
   logic [7:0] part_first_ff,   part_first_in;
   logic [1:0] part_count_ff,   part_count_in;
   logic [3:0] sx_pos_ff,       sx_pos_in;
   logic [3:0] sx_flags_ff,     sx_flags_in;
   logic [7:0] gs_vol_ff,       gs_vol_in;
   logic [7:0] gm_vol_ff,       gm_vol_in;
   logic       rsp_valid_ff,    rsp_valid_in;
   rsp_type    rsp_ff,          rsp_in;
   rsp_type    res;
   logic [7:0] b;
   logic [3:0] p;
   logic [1:0] flen;
   logic [7:0] gs_eff;
   logic [7:0] gm_eff;
   logic [3:0] f;

   assign cmd_pop   = cmd_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;
   assign b         = cmd.data;
   assign p         = sx_pos_ff;
   assign flen      = frame_len(part_status_ff[6:4]);
   assign gs_eff    = (p == SX_GS_VOL_POS) ? b : gs_vol_ff;
   assign gm_eff    = (p == SX_GM_VOL_POS) ? b : gm_vol_ff;

   always_comb begin
      no_data_in     = no_data_ff;
      reset_pend_in  = reset_pend_ff;
      in_sysex_in    = in_sysex_ff;
      part_status_in = part_status_ff;
      part_first_in  = part_first_ff;
      part_count_in  = part_count_ff;
      sx_pos_in      = sx_pos_ff;
      sx_flags_in    = sx_flags_ff;
      gs_vol_in      = gs_vol_ff;
      gm_vol_in      = gm_vol_ff;
      res            = '0;
      res.event_kind = EV_NONE;
      f              = sx_flags_ff;

      case (cmd.kind)
         ACC_DATA_READ: begin
            no_data_in    = 1'b1;
            reset_pend_in = 1'b0;
            res.read_data = DATA_READ_BYTE;
         end
         ACC_STATUS_READ: begin
            res.read_data = no_data_ff ? STATUS_NODATA : STATUS_CLEAR;
         end
         ACC_COMMAND: begin
            if (b == CMD_UART_MODE) begin
               no_data_in = 1'b0;
            end
            if (b == CMD_RESET) begin
               no_data_in     = 1'b0;
               reset_pend_in  = 1'b1;
               part_status_in = '0;
               part_first_in  = '0;
               part_count_in  = '0;
               in_sysex_in    = 1'b0;
               sx_pos_in      = '0;
               sx_flags_in    = '0;
               gs_vol_in      = '0;
               gm_vol_in      = '0;
            end
         end
         ACC_DATA_WRITE: begin
            if (reset_pend_ff) begin
               // ignored until the next data read
            end else if (in_sysex_ff) begin
               gs_vol_in = gs_eff;
               gm_vol_in = gm_eff;
               if (b != MIDI_EOX) begin
                  if (p >= 4'd1 && p <= 4'd7 && p != 4'd2 && b != gs_vol_body(p)) begin
                     f[0] = 1'b0;
                  end
                  if (p >= 4'd1 && p <= 4'd4 && b != gm_vol_body(p)) begin
                     f[1] = 1'b0;
                  end
                  if (p >= SX_GS_RST_END || (p >= 4'd1 && b != gs_reset_body(p))) begin
                     f[2] = 1'b0;
                  end
                  if (p >= SX_GM_RST_END || (p >= 4'd1 && b != gm_reset_body(p))) begin
                     f[3] = 1'b0;
                  end
                  sx_flags_in = f;
                  if (p != SX_POS_MAX) begin
                     sx_pos_in = p + 4'd1;
                  end
               end else begin
                  if ((sx_flags_ff[2] && p == SX_GS_RST_END) ||
                      (sx_flags_ff[3] && p == SX_GM_RST_END)) begin
                     res.event_kind = EV_SYSEX_RESET;
                  end else if (sx_flags_ff[0] && p >= SX_GS_VOL_POS) begin
                     res.event_kind    = EV_VOLUME;
                     res.master_volume = clamp7(gs_eff);
                  end else if (sx_flags_ff[1] && p >= SX_GM_VOL_POS) begin
                     res.event_kind    = EV_VOLUME;
                     res.master_volume = clamp7(gm_eff);
                  end
                  in_sysex_in = 1'b0;
                  sx_pos_in   = '0;
                  sx_flags_in = '0;
                  gs_vol_in   = '0;
                  gm_vol_in   = '0;
               end
            end else if (b[7]) begin
               part_count_in  = '0;
               part_status_in = '0;
               part_first_in  = '0;
               if (b == MIDI_SYSEX) begin
                  in_sysex_in = 1'b1;
                  sx_pos_in   = 4'd1;
                  sx_flags_in = 4'hf;
                  gs_vol_in   = '0;
                  gm_vol_in   = '0;
               end else if (b == MIDI_RESET) begin
                  res.event_kind = EV_SYS_RESET;
               end else if (b < MIDI_SYSEX) begin
                  part_status_in = b;
                  part_count_in  = 2'd1;
               end
            end else if (part_count_ff != 2'd0) begin
               if (part_count_ff == 2'd1 && flen == 2'd3) begin
                  part_first_in = b;
                  part_count_in = 2'd2;
               end else begin
                  res.event_kind = EV_CHANNEL;
                  res.msg_status = part_status_ff;
                  if (flen == 2'd3) begin
                     res.msg_data_one = part_first_ff;
                     res.msg_data_two = b;
                     res.msg_length   = 2'd3;
                  end else begin
                     res.msg_data_one = b;
                     res.msg_length   = 2'd2;
                  end
                  part_count_in  = '0;
                  part_status_in = '0;
                  part_first_in  = '0;
               end
            end
         end
         default: begin
         end
      endcase

      rsp_valid_in = cmd_pop ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);
      rsp_in       = cmd_pop ? res : rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         no_data_ff     <= 1'b1;
         reset_pend_ff  <= 1'b0;
         in_sysex_ff    <= 1'b0;
         part_status_ff <= '0;
         part_first_ff  <= '0;
         part_count_ff  <= '0;
         sx_pos_ff      <= '0;
         sx_flags_ff    <= '0;
         gs_vol_ff      <= '0;
         gm_vol_ff      <= '0;
         rsp_valid_ff   <= 1'b0;
      end else if (cmd_pop) begin
         no_data_ff     <= no_data_in;
         reset_pend_ff  <= reset_pend_in;
         in_sysex_ff    <= in_sysex_in;
         part_status_ff <= part_status_in;
         part_first_ff  <= part_first_in;
         part_count_ff  <= part_count_in;
         sx_pos_ff      <= sx_pos_in;
         sx_flags_ff    <= sx_flags_in;
         gs_vol_ff      <= gs_vol_in;
         gm_vol_ff      <= gm_vol_in;
         rsp_valid_ff   <= rsp_valid_in;
      end else begin
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   a_len_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> ((rsp_ff.event_kind == EV_CHANNEL) == (rsp_ff.msg_length != 2'd0)))
      else $error("message length disagrees with event kind");

   a_pend_clean: assert property (@(posedge clock) disable iff (reset)
      reset_pend_ff |-> (!in_sysex_ff && part_count_ff == 2'd0))
      else $error("framing state live while reset pending");

   a_sysex_excl: assert property (@(posedge clock) disable iff (reset)
      in_sysex_ff |-> (part_count_ff == 2'd0 && sx_pos_ff != 4'd0))
      else $error("sysex and channel framing overlap");

endmodule

// ===== sv/uart_midi_port_framer_unit.sv =====
// Top level of the MIDI port framer: front decode, queue and back end.
//
//  group  dir  beat contents
//  req_   in   tuser: operation; tdata: port_address[15:0], write_data[23:16]
//  rsp_   out  tuser: event_kind; tdata: read_data, msg_status, data_one,
//              data_two, msg_length, master_volume
//  csr_   in   data: base_port
//
// One access per cycle sustained while rsp_ is not stalled; a beat's result is
// registered in the queue stage, then in the back end's output register.
// Two-entry queue lets the front keep taking beats while rsp_ is stalled, until it is full.
// Reset is synchronous; no clearing pass.
module uart_midi_port_framer_unit (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data,    // base_port
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [23:0] req_tdata,   // port_address[15:0], write_data[23:16]
   input  logic        req_tuser,   // operation
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // read_data[7:0], msg_status[15:8],
                                    // msg_data_one[23:16], msg_data_two[31:24],
                                    // msg_length[33:32], master_volume[40:34]
   output logic [2:0]  rsp_tuser    // event_kind
);
   import umpf_pkg::*;

   logic    push_valid;
   cmd_type push_cmd;
   logic    queue_full;
   logic    q_valid;
   cmd_type q_cmd;
   logic    q_pop;
   rsp_type rsp;

   umpf_front u_front (
      .clock      (clock),
      .reset      (reset),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_data   (csr_data),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .queue_full (queue_full)
   );

   umpf_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_cmd   (push_cmd),
      .full       (queue_full),
      .pop_valid  (q_valid),
      .pop_cmd    (q_cmd),
      .pop        (q_pop)
   );

   umpf_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (q_valid),
      .cmd       (q_cmd),
      .cmd_pop   (q_pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp       (rsp)
   );

   assign rsp_tuser = rsp.event_kind;
   assign rsp_tdata = {7'd0, rsp.master_volume, rsp.msg_length, rsp.msg_data_two,
                       rsp.msg_data_one, rsp.msg_status, rsp.read_data};

endmodule
